/* hw/rtl/abpll_pkg.sv */
// Shared types, constants and series tables for the alpha/beta PLL.
package abpll_pkg;

    localparam logic [26:0] TWO_PI_Q24     = 27'd105414357;
    localparam logic [34:0] TWO_PI_Q24_X32 = 35'd3373259424;
    localparam logic [32:0] PI_Q30         = 33'd3373259426;
    localparam logic [31:0] HALF_PI_Q30    = 32'd1686629713;
    localparam logic [30:0] ONE_Q30        = 31'd1073741824;

    localparam logic [3:0] RED_FIRST_IDX = 4'd4;
    localparam logic [3:0] SIN_LAST_IDX  = 4'd5;
    localparam logic [3:0] COS_FIRST_IDX = 4'd6;
    localparam logic [3:0] COS_LAST_IDX  = 4'd12;

    typedef enum logic [2:0] {
        CFG_NOMINAL_FREQ  = 3'd0,
        CFG_SAMPLE_PERIOD = 3'd1,
        CFG_PROP_GAIN     = 3'd2,
        CFG_INT_GAIN      = 3'd3,
        CFG_CORR_LIMIT    = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_AA,
        MUL_BB,
        MUL_FT,
        MUL_RR,
        MUL_XT,
        MUL_NR,
        MUL_QK,
        MUL_RT,
        MUL_CB,
        MUL_SA,
        MUL_EK,
        MUL_UK
    } mul_sel_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_FREQ,
        OP_SQ1,
        OP_SQ2,
        OP_ANG_SUM,
        OP_ANG_RED,
        OP_QUAD_HI,
        OP_QUAD_LO,
        OP_X2,
        OP_N,
        OP_Q,
        OP_T,
        OP_SIN,
        OP_COS,
        OP_E1,
        OP_E2,
        OP_UP,
        OP_IA,
        OP_PC,
        OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQA,
        S_SQB,
        S_FT,
        S_ANG,
        S_RED,
        S_QH,
        S_QL,
        S_RR,
        S_X2,
        S_H1,
        S_H2,
        S_H3,
        S_H4,
        S_SRT,
        S_SIN,
        S_SC,
        S_E1,
        S_E2,
        S_E3,
        S_UP1,
        S_UP2,
        S_IA1,
        S_IA2,
        S_PC,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        mul_sel_t   mul_sel;
        dp_op_t     op;
        logic [3:0] idx;
        logic       sqrt_start;
    } ctrl_cmd_t;

    function automatic logic [7:0] series_div(input logic [3:0] idx);
        logic [7:0] k;
        case (idx)
            4'd0:    k = 8'd156;
            4'd1:    k = 8'd110;
            4'd2:    k = 8'd72;
            4'd3:    k = 8'd42;
            4'd4:    k = 8'd20;
            4'd5:    k = 8'd6;
            4'd6:    k = 8'd182;
            4'd7:    k = 8'd132;
            4'd8:    k = 8'd90;
            4'd9:    k = 8'd56;
            4'd10:   k = 8'd30;
            4'd11:   k = 8'd12;
            4'd12:   k = 8'd2;
            default: k = 8'd1;
        endcase
        return k;
    endfunction

    // floor(2^32 / k)
    function automatic logic [31:0] series_recip(input logic [3:0] idx);
        logic [31:0] r;
        case (idx)
            4'd0:    r = 32'd27531841;
            4'd1:    r = 32'd39045157;
            4'd2:    r = 32'd59652323;
            4'd3:    r = 32'd102261126;
            4'd4:    r = 32'd214748364;
            4'd5:    r = 32'd715827882;
            4'd6:    r = 32'd23598721;
            4'd7:    r = 32'd32537631;
            4'd8:    r = 32'd47721858;
            4'd9:    r = 32'd76695844;
            4'd10:   r = 32'd143165576;
            4'd11:   r = 32'd357913941;
            4'd12:   r = 32'd2147483648;
            default: r = 32'hFFFF_FFFF;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/abpll_sqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle.
module abpll_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    logic        busy_reg;
    logic        busy_next;
    logic [63:0] rad_reg;
    logic [63:0] rad_next;
    logic [63:0] res_reg;
    logic [63:0] res_next;
    logic [63:0] bit_reg;
    logic [63:0] bit_next;
    logic [63:0] trial;

    always_comb begin
        trial     = res_reg + bit_reg;
        busy_next = busy_reg;
        rad_next  = rad_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            rad_next  = radicand;
            res_next  = 64'd0;
            bit_next  = 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (rad_reg >= trial) begin
                rad_next = rad_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg <= rad_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = res_reg[31:0];

endmodule

/* hw/rtl/abpll_ctrl.sv */
// Sequencer for the PLL step: handshakes and datapath commands.
module abpll_ctrl import abpll_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  logic      sqrt_busy,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        out_free;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_free       = !m_valid_reg || m_ready;
        m_valid_next   = m_valid_reg && !m_ready;
        cmd.mul_sel    = MUL_NONE;
        cmd.op         = OP_NONE;
        cmd.idx        = cnt_reg;
        cmd.sqrt_start = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_SQA;
                end
            end
            S_SQA: begin
                cmd.mul_sel = MUL_AA;
                cmd.op      = OP_FREQ;
                state_next  = S_SQB;
            end
            S_SQB: begin
                cmd.mul_sel = MUL_BB;
                cmd.op      = OP_SQ1;
                state_next  = S_FT;
            end
            S_FT: begin
                cmd.mul_sel = MUL_FT;
                cmd.op      = OP_SQ2;
                state_next  = S_ANG;
            end
            S_ANG: begin
                cmd.op         = OP_ANG_SUM;
                cmd.sqrt_start = 1'b1;
                cnt_next       = RED_FIRST_IDX;
                state_next     = S_RED;
            end
            S_RED: begin
                cmd.op = OP_ANG_RED;
                if (cnt_reg == 4'd0) begin
                    state_next = S_QH;
                end else begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            S_QH: begin
                cmd.op     = OP_QUAD_HI;
                state_next = S_QL;
            end
            S_QL: begin
                cmd.op     = OP_QUAD_LO;
                state_next = S_RR;
            end
            S_RR: begin
                cmd.mul_sel = MUL_RR;
                state_next  = S_X2;
            end
            S_X2: begin
                cmd.op     = OP_X2;
                cnt_next   = 4'd0;
                state_next = S_H1;
            end
            S_H1: begin
                cmd.mul_sel = MUL_XT;
                state_next  = S_H2;
            end
            S_H2: begin
                cmd.mul_sel = MUL_NR;
                cmd.op      = OP_N;
                state_next  = S_H3;
            end
            S_H3: begin
                cmd.mul_sel = MUL_QK;
                cmd.op      = OP_Q;
                state_next  = S_H4;
            end
            S_H4: begin
                cmd.op = OP_T;
                if (cnt_reg == SIN_LAST_IDX) begin
                    state_next = S_SRT;
                end else if (cnt_reg == COS_LAST_IDX) begin
                    state_next = S_SC;
                end else begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = S_H1;
                end
            end
            S_SRT: begin
                cmd.mul_sel = MUL_RT;
                state_next  = S_SIN;
            end
            S_SIN: begin
                cmd.op     = OP_SIN;
                cnt_next   = COS_FIRST_IDX;
                state_next = S_H1;
            end
            S_SC: begin
                cmd.op     = OP_COS;
                state_next = S_E1;
            end
            S_E1: begin
                cmd.mul_sel = MUL_CB;
                state_next  = S_E2;
            end
            S_E2: begin
                cmd.mul_sel = MUL_SA;
                cmd.op      = OP_E1;
                state_next  = S_E3;
            end
            S_E3: begin
                cmd.op     = OP_E2;
                state_next = S_UP1;
            end
            S_UP1: begin
                cmd.mul_sel = MUL_EK;
                state_next  = S_UP2;
            end
            S_UP2: begin
                cmd.op     = OP_UP;
                state_next = S_IA1;
            end
            S_IA1: begin
                cmd.mul_sel = MUL_UK;
                state_next  = S_IA2;
            end
            S_IA2: begin
                cmd.op     = OP_IA;
                state_next = S_PC;
            end
            S_PC: begin
                cmd.op     = OP_PC;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free && !sqrt_busy) begin
                    cmd.op       = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* hw/rtl/abpll_datapath.sv */
// Datapath: registers, shared multiplier, angle, sine/cosine series and PI.
module abpll_datapath import abpll_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  ctrl_cmd_t          cmd,
    input  logic               s_run_enable,
    input  logic signed [31:0] s_alpha_in,
    input  logic signed [31:0] s_beta_in,
    input  logic [31:0]        sqrt_root,
    output logic [63:0]        sqrt_radicand,
    output logic signed [25:0] m_cos_out,
    output logic signed [25:0] m_sin_out,
    output logic [26:0]        m_angle_out,
    output logic signed [31:0] m_frequency_out,
    output logic [30:0]        m_magnitude_out,
    output logic signed [31:0] m_phase_error_out
);

    logic signed [31:0] f0_reg;
    logic [30:0]        td_reg;
    logic signed [31:0] kp_reg;
    logic signed [31:0] ki_reg;
    logic [30:0]        lim_reg;

    logic [26:0]        angle_reg;
    logic signed [31:0] ia_reg;
    logic signed [31:0] pc_reg;

    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic [31:0]        aa_reg;
    logic [31:0]        ab_reg;
    logic signed [31:0] freq_reg;
    logic [63:0]        sq_reg;
    logic signed [65:0] prod_reg;
    logic [31:0]        sum_reg;
    logic [31:0]        rem_reg;
    logic [1:0]         quad_reg;
    logic [31:0]        x2_reg;
    logic [30:0]        t_reg;
    logic [31:0]        n_reg;
    logic [31:0]        q_reg;
    logic [24:0]        sv_reg;
    logic signed [25:0] cos_reg;
    logic signed [25:0] sin_reg;
    logic signed [31:0] e1_reg;
    logic signed [31:0] err_reg;
    logic signed [31:0] up_reg;

    logic signed [25:0] cos_out_reg;
    logic signed [25:0] sin_out_reg;
    logic [26:0]        angle_out_reg;
    logic signed [31:0] freq_out_reg;
    logic [30:0]        mag_out_reg;
    logic signed [31:0] err_out_reg;

    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [65:0] prod_full;

    logic [31:0]        alpha_bits;
    logic [31:0]        beta_bits;
    logic [31:0]        abs_a;
    logic [31:0]        abs_b;
    logic [31:0]        delta;
    logic signed [34:0] ang_sum;
    logic signed [34:0] ang_fix;
    logic [31:0]        red_mod;
    logic [32:0]        a30;
    logic [7:0]         div_k;
    logic [31:0]        div_rem;
    logic [32:0]        div_q;
    logic signed [33:0] t_diff;
    logic [32:0]        sin_round;
    logic [31:0]        cos_round;
    logic signed [25:0] cpos;
    logic signed [25:0] spos;
    logic signed [31:0] ia_sum;
    logic signed [31:0] pc_sum;
    logic signed [31:0] lim_s;
    logic signed [31:0] pc_hi;
    logic signed [31:0] pc_fin;
    logic [31:0]        mag_max;
    logic [31:0]        mag_val;

    always_comb begin
        op_a = 33'sd0;
        op_b = 33'sd0;
        case (cmd.mul_sel)
            MUL_AA: begin
                op_a = {1'b0, aa_reg};
                op_b = {1'b0, aa_reg};
            end
            MUL_BB: begin
                op_a = {1'b0, ab_reg};
                op_b = {1'b0, ab_reg};
            end
            MUL_FT: begin
                op_a = {freq_reg[31], freq_reg};
                op_b = {6'd0, td_reg[30:4]};
            end
            MUL_RR: begin
                op_a = {2'd0, rem_reg[30:0]};
                op_b = {2'd0, rem_reg[30:0]};
            end
            MUL_XT: begin
                op_a = {1'b0, x2_reg};
                op_b = {2'd0, t_reg};
            end
            MUL_NR: begin
                op_a = {1'b0, prod_reg[61:30]};
                op_b = {1'b0, series_recip(cmd.idx)};
            end
            MUL_QK: begin
                op_a = {1'b0, prod_reg[63:32]};
                op_b = {25'd0, series_div(cmd.idx)};
            end
            MUL_RT: begin
                op_a = {2'd0, rem_reg[30:0]};
                op_b = {2'd0, t_reg};
            end
            MUL_CB: begin
                op_a = {{7{cos_reg[25]}}, cos_reg};
                op_b = {b_reg[31], b_reg};
            end
            MUL_SA: begin
                op_a = {{7{sin_reg[25]}}, sin_reg};
                op_b = {a_reg[31], a_reg};
            end
            MUL_EK: begin
                op_a = {{5{err_reg[31]}}, err_reg[31:4]};
                op_b = {kp_reg[31], kp_reg};
            end
            MUL_UK: begin
                op_a = {up_reg[31], up_reg};
                op_b = {ki_reg[31], ki_reg};
            end
            default: begin
                op_a = 33'sd0;
                op_b = 33'sd0;
            end
        endcase
    end

    assign prod_full = op_a * op_b;

    always_comb begin
        alpha_bits = s_alpha_in;
        beta_bits  = s_beta_in;
        abs_a      = alpha_bits[31] ? (~alpha_bits + 32'd1) : alpha_bits;
        abs_b      = beta_bits[31] ? (~beta_bits + 32'd1) : beta_bits;

        delta   = {prod_reg[47:20], 4'd0};
        ang_sum = $signed({8'd0, angle_reg}) + $signed({{3{delta[31]}}, delta});
        ang_fix = ang_sum[34] ? (ang_sum + $signed(TWO_PI_Q24_X32)) : ang_sum;
        red_mod = {5'd0, TWO_PI_Q24} << cmd.idx[2:0];
        a30     = {sum_reg[26:0], 6'd0};

        div_k   = series_div(cmd.idx);
        div_rem = n_reg - prod_reg[31:0];
        div_q   = {1'b0, q_reg} + ((div_rem >= {24'd0, div_k}) ? 33'd1 : 33'd0);
        t_diff  = $signed({3'd0, ONE_Q30}) - $signed({1'b0, div_q});

        sin_round = {1'b0, prod_reg[61:30]} + 33'd32;
        cos_round = {1'b0, t_reg} + 32'd32;
        cpos      = {1'b0, cos_round[30:6]};
        spos      = {1'b0, sv_reg};

        ia_sum = (ia_reg >>> 4) + $signed(prod_reg[51:20]);
        pc_sum = up_reg + ia_reg;
        lim_s  = {1'b0, lim_reg};
        pc_hi  = (pc_sum > lim_s) ? lim_s : pc_sum;
        pc_fin = (pc_hi < -lim_s) ? -lim_s : pc_hi;

        mag_max = (aa_reg >= ab_reg) ? aa_reg : ab_reg;
        mag_val = (sqrt_root < mag_max) ? mag_max : sqrt_root;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_reg    <= 32'sd0;
            td_reg    <= 31'd0;
            kp_reg    <= 32'sd0;
            ki_reg    <= 32'sd0;
            lim_reg   <= 31'd0;
            angle_reg <= 27'd0;
            ia_reg    <= 32'sd0;
            pc_reg    <= 32'sd0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_NOMINAL_FREQ:  f0_reg  <= cfg_data;
                    CFG_SAMPLE_PERIOD: td_reg  <= cfg_data[30:0];
                    CFG_PROP_GAIN:     kp_reg  <= cfg_data;
                    CFG_INT_GAIN:      ki_reg  <= cfg_data;
                    CFG_CORR_LIMIT:    lim_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_LOAD: begin
                    if (!s_run_enable) begin
                        angle_reg <= 27'd0;
                        ia_reg    <= 32'sd0;
                        pc_reg    <= 32'sd0;
                    end
                end
                OP_QUAD_HI: angle_reg <= sum_reg[26:0];
                OP_IA:      ia_reg    <= {ia_sum[27:0], 4'd0};
                OP_PC:      pc_reg    <= pc_fin;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_full;
        case (cmd.op)
            OP_LOAD: begin
                a_reg  <= s_alpha_in;
                b_reg  <= s_beta_in;
                aa_reg <= abs_a;
                ab_reg <= abs_b;
            end
            OP_FREQ:    freq_reg <= f0_reg + (pc_reg >>> 4);
            OP_SQ1:     sq_reg   <= prod_reg[63:0];
            OP_SQ2:     sq_reg   <= sq_reg + prod_reg[63:0];
            OP_ANG_SUM: sum_reg  <= ang_fix[31:0];
            OP_ANG_RED: begin
                if (sum_reg >= red_mod) begin
                    sum_reg <= sum_reg - red_mod;
                end
            end
            OP_QUAD_HI: begin
                if (a30 >= PI_Q30) begin
                    rem_reg     <= 32'(a30 - PI_Q30);
                    quad_reg[1] <= 1'b1;
                end else begin
                    rem_reg     <= a30[31:0];
                    quad_reg[1] <= 1'b0;
                end
            end
            OP_QUAD_LO: begin
                if (rem_reg >= HALF_PI_Q30) begin
                    rem_reg     <= rem_reg - HALF_PI_Q30;
                    quad_reg[0] <= 1'b1;
                end else begin
                    quad_reg[0] <= 1'b0;
                end
            end
            OP_X2: begin
                x2_reg <= prod_reg[61:30];
                t_reg  <= ONE_Q30;
            end
            OP_N: n_reg <= prod_reg[61:30];
            OP_Q: q_reg <= prod_reg[63:32];
            OP_T: t_reg <= t_diff[33] ? 31'd0 : t_diff[30:0];
            OP_SIN: begin
                sv_reg <= sin_round[30:6];
                t_reg  <= ONE_Q30;
            end
            OP_COS: begin
                case (quad_reg)
                    2'd0: begin
                        cos_reg <= cpos;
                        sin_reg <= spos;
                    end
                    2'd1: begin
                        cos_reg <= -spos;
                        sin_reg <= cpos;
                    end
                    2'd2: begin
                        cos_reg <= -cpos;
                        sin_reg <= -spos;
                    end
                    default: begin
                        cos_reg <= spos;
                        sin_reg <= -cpos;
                    end
                endcase
            end
            OP_E1: e1_reg  <= prod_reg[55:24];
            OP_E2: err_reg <= e1_reg - $signed(prod_reg[55:24]);
            OP_UP: up_reg  <= {prod_reg[47:20], 4'd0};
            OP_OUT: begin
                cos_out_reg   <= cos_reg;
                sin_out_reg   <= sin_reg;
                angle_out_reg <= angle_reg;
                freq_out_reg  <= freq_reg;
                mag_out_reg   <= mag_val[31] ? 31'h7FFF_FFFF : mag_val[30:0];
                err_out_reg   <= err_reg;
            end
            default: ;
        endcase
    end

    assign sqrt_radicand     = sq_reg;
    assign m_cos_out         = cos_out_reg;
    assign m_sin_out         = sin_out_reg;
    assign m_angle_out       = angle_out_reg;
    assign m_frequency_out   = freq_out_reg;
    assign m_magnitude_out   = mag_out_reg;
    assign m_phase_error_out = err_out_reg;

endmodule

/* hw/rtl/alpha_beta_phase_locked_loop.sv */
// Top level of the alpha/beta phase-locked loop.
//
//   channel  handshake           payload
//   cfg      cfg_wr_en           cfg_index, cfg_data
//   s_       s_valid / s_ready   s_run_enable, s_alpha_in, s_beta_in
//   m_       m_valid / m_ready   cos, sin, angle, frequency, magnitude, phase error
//
// s_ready is high only while idle, so a new item is taken only once the last is done; most
// of the work is the thirteen series steps of sine and cosine on the shared multiplier.
// The magnitude root runs alongside in its own unit.
// Reset clears the loop state and the configuration registers to zero.
// A result waits in the output register; the block finishes the next item and then holds
// in its last state until the output register is free and the root unit is idle.
module alpha_beta_phase_locked_loop import abpll_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_run_enable,
    input  logic signed [31:0] s_alpha_in,
    input  logic signed [31:0] s_beta_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [25:0] m_cos_out,
    output logic signed [25:0] m_sin_out,
    output logic [26:0]        m_angle_out,
    output logic signed [31:0] m_frequency_out,
    output logic [30:0]        m_magnitude_out,
    output logic signed [31:0] m_phase_error_out
);

    ctrl_cmd_t   cmd;
    logic        sqrt_busy;
    logic [31:0] sqrt_root;
    logic [63:0] sqrt_radicand;

    abpll_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sqrt_busy (sqrt_busy),
        .cmd       (cmd)
    );

    abpll_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (sqrt_radicand),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    abpll_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd               (cmd),
        .s_run_enable      (s_run_enable),
        .s_alpha_in        (s_alpha_in),
        .s_beta_in         (s_beta_in),
        .sqrt_root         (sqrt_root),
        .sqrt_radicand     (sqrt_radicand),
        .m_cos_out         (m_cos_out),
        .m_sin_out         (m_sin_out),
        .m_angle_out       (m_angle_out),
        .m_frequency_out   (m_frequency_out),
        .m_magnitude_out   (m_magnitude_out),
        .m_phase_error_out (m_phase_error_out)
    );

endmodule
